[design/msd_pkg.sv]
// Shared types, constants and the segment decoder of the seven-segment display driver.
`default_nettype none
package msd_pkg;

  localparam int DIGITS      = 4;
  localparam int IDX_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W       = $clog2(DIGITS + 1);
  localparam int TXT_MAX     = (DIGITS < 4) ? DIGITS : 4;
  localparam int MAG_W       = 17;
  localparam int RECIP_W     = 16;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam int N_W         = 3;
  localparam int MAX_NUM_DIG = 5;

  localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
  localparam logic [6:0]         SEG_ALL   = 7'h7F;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_NUMBER = 2'd1,
    REQ_TEXT   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_MUL,
    ST_DIG,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [MAG_W-1:0] quot;
    logic [3:0]       rem;
  } div_res_t;

  function automatic logic [6:0] seg_decode(input logic [7:0] code, input logic [6:0] prev);
    logic [6:0] seg;
    seg = prev;
    if (code[7]) begin
      seg = SEG_ALL;
    end else begin
      case (code)
        8'd0:   seg = 7'h3F;
        8'd1:   seg = 7'h06;
        8'd2:   seg = 7'h5B;
        8'd3:   seg = 7'h4F;
        8'd4:   seg = 7'h66;
        8'd5:   seg = 7'h6D;
        8'd6:   seg = 7'h7D;
        8'd7:   seg = 7'h07;
        8'd8:   seg = 7'h7F;
        8'd9:   seg = 7'h6F;
        8'h41:  seg = 7'h77;
        8'h42:  seg = 7'h7C;
        8'h43:  seg = 7'h39;
        8'h44:  seg = 7'h5E;
        8'h45:  seg = 7'h79;
        8'h46:  seg = 7'h71;
        8'h47:  seg = 7'h6F;
        8'h48:  seg = 7'h76;
        8'h68:  seg = 7'h74;
        8'h49:  seg = 7'h30;
        8'h4C:  seg = 7'h38;
        8'h4D:  seg = 7'h15;
        8'h4E:  seg = 7'h54;
        8'h4F:  seg = 7'h3F;
        8'h50:  seg = 7'h73;
        8'h52:  seg = 7'h50;
        8'h53:  seg = 7'h6D;
        8'h54:  seg = 7'h78;
        8'h55:  seg = 7'h3E;
        8'h59:  seg = 7'h6E;
        8'h5A:  seg = 7'h5B;
        8'h2D:  seg = 7'h40;
        default: seg = prev;
      endcase
    end
    return seg;
  endfunction

endpackage
`default_nettype wire

[design/msd_if.sv]
// Request and result channel interfaces of the seven-segment display driver.
`default_nettype none
interface msd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] number_value;
  logic [31:0]        text_chars;
  logic [2:0]         text_length;

  modport source (output valid, output req_type, output number_value,
                  output text_chars, output text_length, input ready);
  modport sink (input valid, input req_type, input number_value,
                input text_chars, input text_length, output ready);
endinterface

interface msd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] segments;
  logic [3:0] digit_enable_n;

  modport source (output valid, output segments, output digit_enable_n, input ready);
  modport sink (input valid, input segments, input digit_enable_n, output ready);
endinterface
`default_nettype wire

[design/multiplexed_seven_segment_driver.sv]
// Top level of the multiplexed seven-segment display driver.
//
//   channel  | direction | payload                                       | handshake
//   in_ch    | in        | req_type, number_value, text_chars, text_length | valid/ready
//   out_ch   | out       | segments, digit_enable_n                      | valid/ready
//
// A tick waits until the result register is free; no new request is accepted meanwhile.
// A text request is taken in the idle state. A number request alternates multiply and digit
// states, one decimal digit per pass of the single divide-by-ten unit, then fills the store.
// Synchronous active-low reset clears the digit store, sets the active count to the digit count and
// clears the scan index, the last segment pattern and the output valid flag.
`default_nettype none
module multiplexed_seven_segment_driver (
  input  logic      clk,
  input  logic      rst_n,
  msd_in_if.sink    in_ch,
  msd_out_if.source out_ch
);
  import msd_pkg::*;

  state_t           state_r, state_nxt;
  logic [7:0]       store_r [DIGITS];
  logic [7:0]       store_nxt [DIGITS];
  logic [CNT_W-1:0] active_count_r, active_count_nxt;
  logic [2:0]       scan_index_r, scan_index_nxt;
  logic [6:0]       last_seg_r, last_seg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_seg_r, out_seg_nxt;
  logic [3:0]       out_en_r, out_en_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [N_W-1:0]   n_r, n_nxt;

  logic             accept;
  logic             slot_free;
  logic             div_en;
  div_res_t         div_res;
  logic [2:0]       use_idx;
  logic [2:0]       text_len;
  logic [2:0]       src;
  logic [7:0]       dig_code;
  logic [15:0]      num_raw;

  msd_div10 u_div10 (
    .clk (clk),
    .en  (div_en),
    .mag (mag_r),
    .res (div_res)
  );

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign accept                = in_ch.valid && in_ch.ready;
  assign slot_free             = !out_valid_r || out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.segments       = out_seg_r;
  assign out_ch.digit_enable_n = out_en_r;
  assign div_en                = (state_r == ST_MUL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(in_ch.req_type))
            REQ_TICK:   state_nxt = ST_TICK;
            REQ_NUMBER: state_nxt = ST_MUL;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_nxt = (mag_r == '0) ? ST_FILL : ST_DIG;
      end
      ST_DIG:  state_nxt = ST_MUL;
      ST_FILL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    store_nxt        = store_r;
    active_count_nxt = active_count_r;
    scan_index_nxt   = scan_index_r;
    last_seg_nxt     = last_seg_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_seg_nxt      = out_seg_r;
    out_en_nxt       = out_en_r;
    mag_nxt          = mag_r;
    neg_nxt          = neg_r;
    n_nxt            = n_r;
    use_idx          = scan_index_r;
    text_len         = (in_ch.text_length > 3'(TXT_MAX)) ? 3'(TXT_MAX) : in_ch.text_length;
    src              = '0;
    dig_code         = neg_r ? (8'd0 - 8'(div_res.rem)) : 8'(div_res.rem);
    num_raw          = in_ch.number_value;

    if (4'(scan_index_r) >= 4'(active_count_r) || 4'(scan_index_r) >= 4'(DIGITS)) begin
      use_idx = '0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && req_t'(in_ch.req_type) == REQ_NUMBER) begin
          neg_nxt = num_raw[15];
          mag_nxt = num_raw[15] ? (MAG_W'(17'h10000) - MAG_W'(num_raw)) : MAG_W'(num_raw);
          n_nxt   = '0;
        end
        if (accept && req_t'(in_ch.req_type) == REQ_TEXT) begin
          for (int k = 0; k < DIGITS; k++) begin
            if (3'(k) < text_len) begin
              src          = text_len - 3'(k) - 3'd1;
              store_nxt[k] = in_ch.text_chars[8 * src[1:0] +: 8];
            end
          end
          active_count_nxt = CNT_W'(text_len);
        end
      end
      ST_TICK: begin
        if (slot_free) begin
          last_seg_nxt  = seg_decode(store_r[use_idx[IDX_W-1:0]], last_seg_r);
          out_seg_nxt   = last_seg_nxt;
          for (int b = 0; b < 4; b++) begin
            out_en_nxt[b] = (use_idx != 3'(b));
          end
          out_valid_nxt  = 1'b1;
          scan_index_nxt = use_idx + 3'd1;
        end
      end
      ST_DIG: begin
        if (4'(n_r) < 4'(DIGITS)) begin
          store_nxt[n_r[IDX_W-1:0]] = dig_code;
        end
        n_nxt   = n_r + 1'b1;
        mag_nxt = div_res.quot;
      end
      ST_FILL: begin
        for (int k = 0; k < DIGITS; k++) begin
          if (4'(k) >= 4'(n_r)) begin
            store_nxt[k] = 8'd0;
          end
        end
        active_count_nxt = (4'(n_r) > 4'(DIGITS)) ? CNT_W'(DIGITS) : CNT_W'(n_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      for (int k = 0; k < DIGITS; k++) begin
        store_r[k] <= 8'd0;
      end
      active_count_r <= CNT_W'(DIGITS);
      scan_index_r   <= '0;
      last_seg_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      store_r        <= store_nxt;
      active_count_r <= active_count_nxt;
      scan_index_r   <= scan_index_nxt;
      last_seg_r     <= last_seg_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_seg_r <= out_seg_nxt;
    out_en_r  <= out_en_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    n_r       <= n_nxt;
  end

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    4'(active_count_r) <= 4'(DIGITS))
    else $error("active digit count exceeds the digit count");

  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones(~out_en_r) <= 1)
    else $error("more than one digit enabled");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_DIG || state_r == ST_FILL) |-> n_r <= N_W'(MAX_NUM_DIG))
    else $error("number conversion produced too many digits");

  a_number_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.req_type == REQ_NUMBER) |=> (state_r == ST_MUL && !in_ch.ready))
    else $error("number request did not start conversion");

endmodule
`default_nettype wire

[design/msd_div10.sv]
// Shared divide-by-ten unit: registered reciprocal product, then quotient and remainder.
`default_nettype none
module msd_div10 (
  input  logic                     clk,
  input  logic                     en,
  input  logic [msd_pkg::MAG_W-1:0] mag,
  output msd_pkg::div_res_t        res
);
  import msd_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]  quot;
  logic [MAG_W-1:0]  diff;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(mag) * PROD_W'(RECIP_TEN);
    end
  end

  assign quot     = MAG_W'(prod_r >> RECIP_SHIFT);
  assign diff     = mag - ((quot << 3) + (quot << 1));
  assign res.quot = quot;
  assign res.rem  = diff[3:0];
endmodule
`default_nettype wire
